// ===== rtl/sfl_pkg.sv =====
package sfl_pkg;

  // request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_ALL_FREE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;   // write one clearing-pass entry
    logic accept;   // capture the input beat
    logic rd;       // issue the cell read
    logic exec;     // update chain state and load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done; // clearing pass at its last entry
  } sts_t;

endpackage

// ===== rtl/slot_free_list_with_epochs.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_action, in_slot_index
// out      output     out_valid / out_stall out_status, out_granted_index,
//                                           out_slot_epoch, out_free_slots
//
// each request passes the steps capture, cell read and update in turn;
// the registered read of the single cell memory needs the read step
// after reset a clearing pass over all SLOTS entries rebuilds the chain and
// zeroes the epochs; no request is taken meanwhile
// a stalled result is held in its register; the next request is taken
// and read, then waits in the update step until the result beat leaves
module slot_free_list_with_epochs #(
  parameter int SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [6:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_granted_index,
  output logic [15:0] out_slot_epoch,
  output logic [6:0]  out_free_slots
);

  sfl_pkg::cmd_t cmd;
  sfl_pkg::sts_t sts;

  // sequencer
  sfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // chain state and cell memory
  sfl_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_action),
    .in_slot_index     (in_slot_index),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_slot_epoch    (out_slot_epoch),
    .out_free_slots    (out_free_slots)
  );

endmodule

// ===== rtl/sfl_ram.sv =====
module sfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sfl_ctrl.sv =====
module sfl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sfl_pkg::sts_t sts,
  output sfl_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // handshake and commands
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    cmd.clr_wr = (state_r == S_CLEAR);
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.rd     = (state_r == S_READ);
    cmd.exec   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // result beat held until taken
  always_comb begin
    out_valid_nxt = cmd.exec || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/sfl_dp.sv =====
module sfl_dp #(
  parameter int SLOTS = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sfl_pkg::cmd_t cmd,
  output sfl_pkg::sts_t sts,
  input  logic          in_action,
  input  logic [6:0]    in_slot_index,
  output logic [1:0]    out_status,
  output logic [6:0]    out_granted_index,
  output logic [15:0]   out_slot_epoch,
  output logic [6:0]    out_free_slots
);

  localparam int IW = $clog2(SLOTS);
  localparam int DW = IW + 16;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic          act_r;
  logic [6:0]    idx_r;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] total_r, total_nxt;
  logic [IW-1:0] clr_r;

  logic [1:0]    status_r;
  logic [6:0]    granted_r;
  logic [15:0]   epoch_r;
  logic [6:0]    free_r;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic [IW-1:0] rd_link;
  logic [15:0]   rd_epoch;
  logic [IW-1:0] idx_slot;
  logic          idx_bad, is_free, do_push;
  logic [1:0]    status;
  logic [IW-1:0] granted;
  logic [15:0]   epoch;
  logic [IW-1:0] clr_link;

  assign rd_link  = rdata[DW-1:16];
  assign rd_epoch = rdata[15:0];
  assign idx_slot = IW'(idx_r);
  assign idx_bad  = 32'(idx_r) >= 32'(SLOTS);
  assign is_free  = (act_r == sfl_pkg::ACT_FREE);
  assign sts.clr_done = (clr_r == LAST);

  // last cell links back to slot zero
  assign clr_link = (clr_r == LAST) ? '0 : clr_r + IW'(1);

  // pop or push decision
  always_comb begin
    status    = sfl_pkg::STS_OK;
    granted   = '0;
    epoch     = '0;
    head_nxt  = head_r;
    total_nxt = total_r;
    do_push   = 1'b0;
    if (!is_free) begin
      if (total_r == '0) begin
        status = sfl_pkg::STS_FULL;
      end else begin
        granted   = head_r;
        epoch     = rd_epoch;
        head_nxt  = rd_link;
        total_nxt = total_r - IW'(1);
      end
    end else begin
      if (total_r == LAST || idx_bad) begin
        status = sfl_pkg::STS_ALL_FREE;
      end else begin
        granted   = idx_slot;
        epoch     = rd_epoch + 16'd1;
        head_nxt  = idx_slot;
        total_nxt = total_r + IW'(1);
        do_push   = 1'b1;
      end
    end
  end

  // cell port: clearing pass or pushed slot
  always_comb begin
    re    = cmd.rd;
    raddr = is_free ? idx_slot : head_r;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = {clr_link, 16'd0};
    end else begin
      we    = cmd.exec && do_push;
      waddr = idx_slot;
      wdata = {head_r, epoch};
    end
  end

  sfl_ram #(
    .WIDTH(DW),
    .DEPTH(SLOTS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // chain head, count and clearing address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= IW'(1);
      total_r <= LAST;
      clr_r   <= '0;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + IW'(1);
      if (cmd.exec) begin
        head_r  <= head_nxt;
        total_r <= total_nxt;
      end
    end
  end

  // input capture and result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= in_action;
      idx_r <= in_slot_index;
    end
    if (cmd.exec) begin
      status_r  <= status;
      granted_r <= 7'(granted);
      epoch_r   <= epoch;
      free_r    <= 7'(total_nxt);
    end
  end

  assign out_status        = status_r;
  assign out_granted_index = granted_r;
  assign out_slot_epoch    = epoch_r;
  assign out_free_slots    = free_r;

endmodule

// ===== test/tb_slot_free_list_with_epochs.sv =====
`timescale 1ns / 1ps

module tb_slot_free_list_with_epochs;

  localparam int SLOT_COUNT   = 128;
  localparam int TARGET_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  // one grant or refusal as seen on the result channel
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  slot;
    logic [15:0] epoch;
    logic [6:0]  free_left;
  } slot_grant_t;

  // shadow copy of the free chain and epochs, plus grants still owed by the block
  class slot_alloc_scoreboard;
    logic [6:0]  chain_head;
    logic [6:0]  next_link [SLOT_COUNT];
    logic [15:0] slot_epoch [SLOT_COUNT];
    int          free_count;
    int          held_slots [$];
    slot_grant_t grant_q [$];
    int          mismatches;

    function new();
      int i;
      for (i = 0; i < SLOT_COUNT; i++) begin
        next_link[i]  = 7'((i + 1) % SLOT_COUNT);
        slot_epoch[i] = '0;
      end
      chain_head = 7'd1;
      free_count = SLOT_COUNT - 1;
      mismatches = 0;
    endfunction

    // work out the grant for an accepted request beat and update the shadow chain
    function void note_request(logic act, logic [6:0] idx);
      slot_grant_t g;
      int          k;
      bit          found;
      g        = '0;
      g.status = sfl_pkg::STS_OK;
      if (act == sfl_pkg::ACT_ALLOC) begin
        if (free_count == 0) begin
          g.status = sfl_pkg::STS_FULL;
        end else begin
          g.slot     = chain_head;
          g.epoch    = slot_epoch[chain_head];
          chain_head = next_link[chain_head];
          free_count--;
          held_slots.push_back(int'(g.slot));
        end
      end else if (free_count >= SLOT_COUNT - 1) begin
        g.status = sfl_pkg::STS_ALL_FREE;
      end else begin
        // slot 0 and double frees are pushed like any other slot
        next_link[idx]  = chain_head;
        chain_head      = idx;
        slot_epoch[idx] = slot_epoch[idx] + 16'd1;
        free_count++;
        g.slot  = idx;
        g.epoch = slot_epoch[idx];
        found   = 1'b0;
        for (k = 0; k < held_slots.size() && !found; k++) begin
          if (held_slots[k] == idx) begin
            held_slots.delete(k);
            found = 1'b1;
          end
        end
      end
      g.free_left = 7'(free_count);
      grant_q.push_back(g);
    endfunction

    // compare a result beat with the oldest owed grant
    function void check_result(logic [1:0] st, logic [6:0] sl, logic [15:0] ep,
                               logic [6:0] fr);
      slot_grant_t want;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: status %0d slot %0d epoch %0d free %0d",
                   st, sl, ep, fr);
        return;
      end
      want = grant_q.pop_front();
      if (st !== want.status || sl !== want.slot || ep !== want.epoch ||
          fr !== want.free_left) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"%0t grant mismatch: exp status %0d slot %0d epoch %0d free %0d,",
                    " got %0d %0d %0d %0d"},
                   $realtime, want.status, want.slot, want.epoch, want.free_left,
                   st, sl, ep, fr);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [6:0]  in_slot_index;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [6:0]  out_granted_index;
  logic [15:0] out_slot_epoch;
  logic [6:0]  out_free_slots;

  slot_alloc_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int items_sent;

  slot_free_list_with_epochs u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_slot_epoch    (out_slot_epoch),
    .out_free_slots    (out_free_slots)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_status, out_granted_index, out_slot_epoch, out_free_slots);
    end
  end

  // present one request beat, hold it until taken, then log it
  task automatic send_item(input logic act, input logic [6:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_slot_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(act, idx);
    items_sent++;
  endtask

  // run ends here if the block hangs
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int phase;
    int mode;
    int len;
    int alloc_pct;
    int phase_end;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = sfl_pkg::ACT_ALLOC;
    in_slot_index = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    items_sent    = 0;
    sb            = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // frees refused while the whole page is free
    send_item(sfl_pkg::ACT_FREE, 7'd5);
    send_item(sfl_pkg::ACT_FREE, 7'd127);
    send_item(sfl_pkg::ACT_FREE, 7'd0);
    // allocs walk the chain in order; index field ignored
    send_item(sfl_pkg::ACT_ALLOC, 7'd127);
    send_item(sfl_pkg::ACT_ALLOC, 7'd0);
    send_item(sfl_pkg::ACT_ALLOC, 7'd85);
    // frees bump epochs, reallocs hand them back
    send_item(sfl_pkg::ACT_FREE, 7'd2);
    send_item(sfl_pkg::ACT_FREE, 7'd1);
    send_item(sfl_pkg::ACT_ALLOC, 7'd42);
    send_item(sfl_pkg::ACT_ALLOC, 7'd0);
    // slot 0 is pushed unchecked
    send_item(sfl_pkg::ACT_FREE, 7'd0);
    send_item(sfl_pkg::ACT_ALLOC, 7'd0);
    // top slot freed while still on the chain
    send_item(sfl_pkg::ACT_FREE, 7'd127);
    send_item(sfl_pkg::ACT_ALLOC, 7'd127);
    send_item(sfl_pkg::ACT_ALLOC, 7'd0);
    // double free of the same slot
    send_item(sfl_pkg::ACT_FREE, 7'd3);
    send_item(sfl_pkg::ACT_FREE, 7'd3);
    send_item(sfl_pkg::ACT_ALLOC, 7'd1);
    send_item(sfl_pkg::ACT_ALLOC, 7'd2);
    send_item(sfl_pkg::ACT_ALLOC, 7'd4);
    send_item(sfl_pkg::ACT_FREE, 7'd1);

    // random traffic under four back-pressure regimes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 81;
        end
        default: begin
          send_idle_pct = 38;
          stall_pct     = 38;
        end
      endcase
      phase_end = TARGET_ITEMS * (phase + 1) / 4;
      while (items_sent < phase_end) begin
        mode = $urandom_range(4);
        case (mode)
          3: begin
            // drain the chain dry, then knock on a full page
            while (sb.free_count > 0)
              send_item(sfl_pkg::ACT_ALLOC, 7'($urandom_range(127)));
            repeat ($urandom_range(2, 5))
              send_item(sfl_pkg::ACT_ALLOC, 7'($urandom_range(127)));
          end
          4: begin
            // hand every slot back, then free into a full chain
            while (sb.held_slots.size() > 0 && sb.free_count < SLOT_COUNT - 1)
              send_item(sfl_pkg::ACT_FREE,
                        7'(sb.held_slots[$urandom_range(sb.held_slots.size() - 1)]));
            repeat ($urandom_range(2, 4))
              send_item(sfl_pkg::ACT_FREE, 7'($urandom_range(127)));
          end
          default: begin
            // mixed run leaning to fill, to release or balanced
            len       = $urandom_range(20, 150);
            alloc_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            repeat (len) begin
              if ($urandom_range(99) < 4) begin
                // stray free, often a double free
                send_item(sfl_pkg::ACT_FREE, 7'($urandom_range(127)));
              end else if (sb.held_slots.size() == 0 ||
                           $urandom_range(99) < alloc_pct) begin
                send_item(sfl_pkg::ACT_ALLOC, 7'($urandom_range(127)));
              end else begin
                send_item(sfl_pkg::ACT_FREE,
                          7'(sb.held_slots[$urandom_range(sb.held_slots.size() - 1)]));
              end
            end
          end
        endcase
      end
    end
    in_valid <= 1'b0;

    // let owed grants arrive, then watch for strays
    while (sb.grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.grant_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfl_pkg.sv
rtl/sfl_ram.sv
rtl/sfl_ctrl.sv
rtl/sfl_dp.sv
rtl/slot_free_list_with_epochs.sv
test/tb_slot_free_list_with_epochs.sv
